>>> sv/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg: shared types and constants of the 3x3 strict local maximum core
// Holds the frame size limits, the sample and job types passed from the
// front end to the decision back end, and the register index codes.
// ----------------------------------------------------------------------------
package slm_pkg;

   // Frame and sample geometry
   localparam int MAX_DIM     = 128;
   localparam int SAMPLE_BITS = 16;
   localparam int POS_BITS    = $clog2(MAX_DIM);
   localparam int CFG_BITS    = 8;
   localparam int PEAK_BITS   = 15;

   // Job queue between front end and back end (depth is a power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_TOTAL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COL_TOTAL = 2'd1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // 3x3 window: [row][col], row 2 / col 2 is the newest sample
   typedef sample_type [2:0][2:0] window_type;

   // One input beat worth of pending decisions
   typedef struct packed {
      window_type           win;
      logic [POS_BITS-1:0]  row;
      logic [POS_BITS-1:0]  col;
      logic                 row_ge1;
      logic                 row_ge2;
      logic                 col_ge1;
      logic                 col_ge2;
      logic                 last_row;
      logic                 last_col;
   } job_type;

endpackage

>>> sv/slm_ram.sv
// ----------------------------------------------------------------------------
// slm_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module slm_ram #(
   parameter  int WIDTH     = 32,
   parameter  int DEPTH     = 128,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/slm_front.sv
// ----------------------------------------------------------------------------
// slm_front: sample intake, line stores and window
// Accepts sample beats, tracks the raster position, reads and updates the
// two line stores (packed side by side in one RAM), shifts the 3x3 window
// and pushes a decision job whenever a beat completes one or more pixels.
// ----------------------------------------------------------------------------
module slm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [slm_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [slm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [slm_pkg::CFG_BITS-1:0]          csr_data,
   output logic                                  cfg_clear,
   input  logic [slm_pkg::COUNT_BITS-1:0]        q_count,
   output logic                                  q_push,
   output slm_pkg::job_type                      q_job
);

   localparam int S = slm_pkg::SAMPLE_BITS;
   localparam int P = slm_pkg::POS_BITS;
   localparam int C = slm_pkg::COUNT_BITS;

   // Map a size register to the index of the last row or column
   function automatic logic [P-1:0] last_index(input logic [slm_pkg::CFG_BITS-1:0] v);
      logic [P-1:0] idx;
      if (v == '0) begin
         idx = '0;
      end else if (int'(v) > slm_pkg::MAX_DIM) begin
         idx = P'(slm_pkg::MAX_DIM - 1);
      end else begin
         idx = P'(v - 1'b1);
      end
      return idx;
   endfunction

   logic             acc;
   logic             csr_write;
   logic [P-1:0]     row_last_ff, row_last_in;
   logic [P-1:0]     col_last_ff, col_last_in;
   logic [P-1:0]     row_pos_ff, row_pos_in;
   logic [P-1:0]     col_pos_ff, col_pos_in;
   logic             s1_valid_ff, s1_valid_in;
   logic signed [S-1:0] s1_sample_ff;
   logic [P-1:0]     s1_row_ff;
   logic [P-1:0]     s1_col_ff;
   logic             byp_hit_ff, byp_hit_in;
   logic [2*S-1:0]   byp_data_ff;
   logic [2*S-1:0]   ram_rd_data;
   logic [2*S-1:0]   ram_wr_data;
   logic [2*S-1:0]   line_data;
   slm_pkg::window_type win_ff, win_in;
   logic             row_ge1, col_ge1, last_row, last_col;

   assign acc       = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Hold intake while the queue may not take the job in flight plus one more
   assign req_stall = ({1'b0, q_count} + {{C{1'b0}}, s1_valid_ff})
                      >= (C+1)'(slm_pkg::QUEUE_DEPTH);

   // Decode register writes; a write to a known register restarts the frame
   always_comb begin
      row_last_in = row_last_ff;
      col_last_in = col_last_ff;
      cfg_clear   = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            slm_pkg::REG_ROW_TOTAL: begin
               row_last_in = last_index(csr_data);
               cfg_clear   = 1'b1;
            end
            slm_pkg::REG_COL_TOTAL: begin
               col_last_in = last_index(csr_data);
               cfg_clear   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Advance the raster position on each accepted beat
   always_comb begin
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      if (cfg_clear) begin
         row_pos_in = '0;
         col_pos_in = '0;
      end else if (acc) begin
         if (col_pos_ff == col_last_ff) begin
            col_pos_in = '0;
            row_pos_in = (row_pos_ff == row_last_ff) ? '0 : row_pos_ff + 1'b1;
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
         end
      end
   end

   assign s1_valid_in = acc;

   // Forward the line-store write that lands on the column being read
   assign byp_hit_in = s1_valid_ff && (s1_col_ff == col_pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_last_ff <= '0;
         col_last_ff <= '0;
         row_pos_ff  <= '0;
         col_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_last_ff <= row_last_in;
         col_last_ff <= col_last_in;
         row_pos_ff  <= row_pos_in;
         col_pos_ff  <= col_pos_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture the accepted beat for the line-store stage
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_sample_ff <= req_sample;
         s1_row_ff    <= row_pos_ff;
         s1_col_ff    <= col_pos_ff;
         byp_hit_ff   <= byp_hit_in;
         byp_data_ff  <= ram_wr_data;
      end
   end

   // Line stores: upper half is the older line, lower half the recent line
   assign line_data   = byp_hit_ff ? byp_data_ff : ram_rd_data;
   assign ram_wr_data = {line_data[S-1:0], s1_sample_ff};

   slm_ram #(
      .WIDTH (2*S),
      .DEPTH (slm_pkg::MAX_DIM)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (acc),
      .rd_addr (col_pos_ff),
      .rd_data (ram_rd_data)
   );

   // Shift the window left and load the new column
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = line_data[2*S-1:S];
      win_in[1][2] = line_data[S-1:0];
      win_in[2][2] = s1_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_ff <= win_in;
      end
   end

   // Classify the beat: which pixels it completes
   assign row_ge1  = (s1_row_ff != '0);
   assign col_ge1  = (s1_col_ff != '0);
   assign last_row = (s1_row_ff == row_last_ff);
   assign last_col = (s1_col_ff == col_last_ff);

   always_comb begin
      q_job.win      = win_in;
      q_job.row      = s1_row_ff;
      q_job.col      = s1_col_ff;
      q_job.row_ge1  = row_ge1;
      q_job.row_ge2  = (s1_row_ff > P'(1));
      q_job.col_ge1  = col_ge1;
      q_job.col_ge2  = (s1_col_ff > P'(1));
      q_job.last_row = last_row;
      q_job.last_col = last_col;
   end

   assign q_push = s1_valid_ff && (row_ge1 || last_row) && (col_ge1 || last_col);

   // Position never leaves the configured frame
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (row_pos_ff <= row_last_ff) && (col_pos_ff <= col_last_ff))
      else $error("raster position outside frame");

endmodule

>>> sv/slm_queue.sv
// ----------------------------------------------------------------------------
// slm_queue: job queue between front end and back end
// Small register FIFO; lets the intake keep taking beats while the result
// side is stalled or busy with a multi-pixel job.
// ----------------------------------------------------------------------------
module slm_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  slm_pkg::job_type               push_job,
   input  logic                           pop,
   output logic                           head_valid,
   output slm_pkg::job_type               head_job,
   output logic [slm_pkg::COUNT_BITS-1:0] count
);

   localparam int PB = slm_pkg::PTR_BITS;
   localparam int CB = slm_pkg::COUNT_BITS;

   slm_pkg::job_type slot_ff [slm_pkg::QUEUE_DEPTH];
   logic [PB-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0]    count_ff, count_in;

   // Advance pointers and occupancy
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + CB'(push) - CB'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CB'(slm_pkg::QUEUE_DEPTH)))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job queue underflow");

endmodule

>>> sv/slm_back.sv
// ----------------------------------------------------------------------------
// slm_back: peak decision and result output
// Walks the one to four pixels of the job at the queue head, one per cycle
// while the result side is not stalled, compares each against its in-frame
// neighbours, keeps the running peak count and drives the registered result channel.
// ----------------------------------------------------------------------------
module slm_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   cfg_clear,
   input  logic                                   q_valid,
   input  slm_pkg::job_type                       q_job,
   output logic                                   q_pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [slm_pkg::SAMPLE_BITS-1:0] rsp_value,
   output logic [slm_pkg::POS_BITS-1:0]           rsp_row_index,
   output logic [slm_pkg::POS_BITS-1:0]           rsp_col_index,
   output logic                                   rsp_is_peak,
   output logic [slm_pkg::PEAK_BITS-1:0]          rsp_peak_total,
   output logic                                   rsp_last_of_run,
   output logic                                   rsp_frame_done
);

   localparam int S  = slm_pkg::SAMPLE_BITS;
   localparam int P  = slm_pkg::POS_BITS;
   localparam int PK = slm_pkg::PEAK_BITS;

   // Strict maximum over the in-frame part of the 3x3 around (ci, cj)
   function automatic logic peak_check(input slm_pkg::window_type w,
                                       input logic rsel, input logic csel,
                                       input logic up_ok, input logic down_ok,
                                       input logic left_ok, input logic right_ok);
      logic [1:0] ci, cj, ki, kj;
      logic       pk, row_ok, col_ok;
      ci = {1'b0, rsel} + 2'd1;
      cj = {1'b0, csel} + 2'd1;
      pk = 1'b1;
      for (int di = 0; di < 3; di++) begin
         for (int dj = 0; dj < 3; dj++) begin
            ki     = ci + 2'(di) - 2'd1;
            kj     = cj + 2'(dj) - 2'd1;
            row_ok = (di == 0) ? up_ok   : ((di == 2) ? down_ok  : 1'b1);
            col_ok = (dj == 0) ? left_ok : ((dj == 2) ? right_ok : 1'b1);
            if (!(di == 1 && dj == 1) && row_ok && col_ok
                && (ki != 2'd3) && (kj != 2'd3)) begin
               if ($signed(w[ki][kj]) >= $signed(w[ci][cj])) begin
                  pk = 1'b0;
               end
            end
         end
      end
      return pk;
   endfunction

   logic              first_ff, first_in;
   logic              rsel_ff, rsel_in;
   logic              csel_ff, csel_in;
   logic [PK-1:0]     peak_cnt_ff, peak_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [S-1:0] value_ff;
   logic [P-1:0]      row_ff, col_ff;
   logic              is_peak_ff, last_ff, done_ff;
   logic [PK-1:0]     total_ff;

   logic              advance;
   logic              cur_r, cur_c;
   logic              row_end, col_end, last_dec;
   logic              pk;
   logic              frame_end;
   logic [PK-1:0]     peak_new;
   logic [1:0]        ci, cj;

   // Pick the pixel of the head job to decide this cycle
   assign cur_r   = first_ff ? !q_job.row_ge1 : rsel_ff;
   assign cur_c   = first_ff ? !q_job.col_ge1 : csel_ff;
   assign row_end = (cur_r == q_job.last_row);
   assign col_end = (cur_c == q_job.last_col);
   assign last_dec = row_end && col_end;

   assign advance = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop   = advance && last_dec;

   assign ci = {1'b0, cur_r} + 2'd1;
   assign cj = {1'b0, cur_c} + 2'd1;

   assign pk = peak_check(q_job.win, cur_r, cur_c,
                          cur_r ? q_job.row_ge1 : q_job.row_ge2, !cur_r,
                          cur_c ? q_job.col_ge1 : q_job.col_ge2, !cur_c);

   assign frame_end = cur_r && cur_c;
   assign peak_new  = peak_cnt_ff + PK'(pk);

   // Step through rows, then columns within a row
   always_comb begin
      first_in    = first_ff;
      rsel_in     = rsel_ff;
      csel_in     = csel_ff;
      peak_cnt_in = peak_cnt_ff;
      if (cfg_clear) begin
         peak_cnt_in = '0;
      end else if (advance) begin
         peak_cnt_in = frame_end ? '0 : peak_new;
         if (last_dec) begin
            first_in = 1'b1;
         end else if (col_end) begin
            first_in = 1'b0;
            rsel_in  = 1'b1;
            csel_in  = !q_job.col_ge1;
         end else begin
            first_in = 1'b0;
            rsel_in  = cur_r;
            csel_in  = 1'b1;
         end
      end
   end

   // Hold the result until taken; load the next decision behind it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         rsel_ff      <= 1'b0;
         csel_ff      <= 1'b0;
         peak_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         rsel_ff      <= rsel_in;
         csel_ff      <= csel_in;
         peak_cnt_ff  <= peak_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff   <= q_job.win[ci][cj];
         row_ff     <= cur_r ? q_job.row : q_job.row - 1'b1;
         col_ff     <= cur_c ? q_job.col : q_job.col - 1'b1;
         is_peak_ff <= pk;
         total_ff   <= peak_new;
         last_ff    <= last_dec;
         done_ff    <= frame_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = value_ff;
   assign rsp_row_index   = row_ff;
   assign rsp_col_index   = col_ff;
   assign rsp_is_peak     = is_peak_ff;
   assign rsp_peak_total  = total_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_frame_done  = done_ff;

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> rsp_last_of_run)
      else $error("frame end decision is not the last of its beat");

   a_peak_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_peak) |-> (rsp_peak_total != '0))
      else $error("peak reported with zero running count");

endmodule

>>> sv/strict_local_max_3x3_core.sv
// ----------------------------------------------------------------------------
// strict_local_max_3x3_core: streaming 3x3 strict local maximum detector
// Flow: a sample is registered in the line-store stage, then pushed as a
//   job into the queue, and its results are registered at the result port;
//   a beat that completes k pixels gives k results (k from 0 to 4).
// Throughput: one sample per cycle while each completes at most one pixel and
//   rsp_stall is low; the result port, one decision per cycle, rules the last row.
// Reset: frame set to 1x1, position and peak count zero; line RAM not cleared.
// ----------------------------------------------------------------------------
module strict_local_max_3x3_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [slm_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [slm_pkg::SAMPLE_BITS-1:0] rsp_value,
   output logic [slm_pkg::POS_BITS-1:0]           rsp_row_index,
   output logic [slm_pkg::POS_BITS-1:0]           rsp_col_index,
   output logic                                   rsp_is_peak,
   output logic [slm_pkg::PEAK_BITS-1:0]          rsp_peak_total,
   output logic                                   rsp_last_of_run,
   output logic                                   rsp_frame_done,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [slm_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [slm_pkg::CFG_BITS-1:0]           csr_data
);

   logic                           cfg_clear;
   logic                           q_push;
   slm_pkg::job_type               q_push_job;
   logic                           q_pop;
   logic                           q_valid;
   slm_pkg::job_type               q_head_job;
   logic [slm_pkg::COUNT_BITS-1:0] q_count;

   // Intake, line stores and window
   slm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg_clear  (cfg_clear),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_job      (q_push_job)
   );

   // Decouple intake from result side
   slm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head_job),
      .count      (q_count)
   );

   // Decide pixels and drive results
   slm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg_clear       (cfg_clear),
      .q_valid         (q_valid),
      .q_job           (q_head_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_row_index   (rsp_row_index),
      .rsp_col_index   (rsp_col_index),
      .rsp_is_peak     (rsp_is_peak),
      .rsp_peak_total  (rsp_peak_total),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done)
   );

endmodule

>>> bench/strict_local_max_3x3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_local_max_3x3_checker: decision checker for the 3x3 peak core
// Watches the register, sample and result channels. Every accepted sample is
// placed in a copy of the frame and every pixel whose clipped neighbourhood
// is now complete is decided from that copy. The decisions are queued in
// raster order and each result beat is compared field by field with the
// oldest one. Mismatches and beats with nothing due are counted.
// ----------------------------------------------------------------------------
module strict_local_max_3x3_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic signed [slm_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic signed [slm_pkg::SAMPLE_BITS-1:0] rsp_value,
   input  logic [slm_pkg::POS_BITS-1:0]           rsp_row_index,
   input  logic [slm_pkg::POS_BITS-1:0]           rsp_col_index,
   input  logic                                   rsp_is_peak,
   input  logic [slm_pkg::PEAK_BITS-1:0]          rsp_peak_total,
   input  logic                                   rsp_last_of_run,
   input  logic                                   rsp_frame_done,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [slm_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [slm_pkg::CFG_BITS-1:0]           csr_data,
   output int                                     failures,
   output int                                     pending
);
   import slm_pkg::*;

   typedef struct packed {
      sample_type            value;
      logic [POS_BITS-1:0]   row_index;
      logic [POS_BITS-1:0]   col_index;
      logic                  is_peak;
      logic [PEAK_BITS-1:0]  peak_total;
      logic                  last_of_run;
      logic                  frame_done;
   } decision_type;

   decision_type          decisions_due[$];
   decision_type          oldest;
   sample_type            frame_pixels [MAX_DIM][MAX_DIM];
   logic [CFG_BITS-1:0]   row_setting;
   logic [CFG_BITS-1:0]   col_setting;
   int                    cur_row;
   int                    cur_col;
   logic [PEAK_BITS-1:0]  peaks_in_frame;
   int                    mismatch_count = 0;

   assign failures = mismatch_count;

   // Map a register value onto the frame size actually used
   function automatic int clamp_dim(input logic [CFG_BITS-1:0] setting);
      if (setting == 0) return 1;
      if (setting > MAX_DIM) return MAX_DIM;
      return setting;
   endfunction

   // Strictly greater than every neighbour that lies inside the frame
   function automatic bit strict_peak(input int i, input int j, input int nr, input int nc);
      sample_type centre;
      int         pi;
      int         pj;
      centre = frame_pixels[i][j];
      for (int di = -1; di <= 1; di++) begin
         for (int dj = -1; dj <= 1; dj++) begin
            pi = i + di;
            pj = j + dj;
            if ((di != 0 || dj != 0) && pi >= 0 && pj >= 0 && pi < nr && pj < nc) begin
               if (centre <= frame_pixels[pi][pj]) return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   // Store one sample and queue every decision it completes
   task automatic take_sample(input sample_type s);
      int           nr;
      int           nc;
      int           row_list[2];
      int           col_list[2];
      int           nrows;
      int           ncols;
      int           total;
      int           k;
      int           i;
      int           j;
      decision_type d;
      nr = clamp_dim(row_setting);
      nc = clamp_dim(col_setting);
      if (cur_row >= nr || cur_col >= nc) begin
         cur_row        = 0;
         cur_col        = 0;
         peaks_in_frame = '0;
      end
      frame_pixels[cur_row][cur_col] = s;

      nrows = 0;
      ncols = 0;
      if (cur_row >= 1) begin
         row_list[nrows] = cur_row - 1;
         nrows++;
      end
      if (cur_row == nr - 1) begin
         row_list[nrows] = cur_row;
         nrows++;
      end
      if (cur_col >= 1) begin
         col_list[ncols] = cur_col - 1;
         ncols++;
      end
      if (cur_col == nc - 1) begin
         col_list[ncols] = cur_col;
         ncols++;
      end

      total = nrows * ncols;
      k     = 0;
      for (int a = 0; a < nrows; a++) begin
         for (int b = 0; b < ncols; b++) begin
            i         = row_list[a];
            j         = col_list[b];
            d.is_peak = strict_peak(i, j, nr, nc);
            if (d.is_peak) peaks_in_frame = peaks_in_frame + 1'b1;
            d.value       = frame_pixels[i][j];
            d.row_index   = i[POS_BITS-1:0];
            d.col_index   = j[POS_BITS-1:0];
            d.peak_total  = peaks_in_frame;
            d.last_of_run = (k == total - 1);
            d.frame_done  = (i == nr - 1) && (j == nc - 1);
            decisions_due.push_back(d);
            k++;
         end
      end

      // Advance the raster position, wrapping into the next frame
      cur_col++;
      if (cur_col >= nc) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= nr) begin
            cur_row        = 0;
            peaks_in_frame = '0;
         end
      end
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch at (%0d,%0d), expected %0h, actual %0h",
                  $time, field, oldest.row_index, oldest.col_index, want, got);
         mismatch_count++;
      end
   endtask

   // Watch all three channels at each edge; compare before queuing new work
   always @(posedge clock) begin
      if (reset) begin
         decisions_due.delete();
         row_setting    = 8'd1;
         col_setting    = 8'd1;
         cur_row        = 0;
         cur_col        = 0;
         peaks_in_frame = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decisions_due.size() == 0) begin
               $display("%0t: result beat with no decision due (row %0d, col %0d)",
                        $time, rsp_row_index, rsp_col_index);
               mismatch_count++;
            end else begin
               oldest = decisions_due.pop_front();
               check_field("value", oldest.value, rsp_value);
               check_field("row_index", oldest.row_index, rsp_row_index);
               check_field("col_index", oldest.col_index, rsp_col_index);
               check_field("is_peak", oldest.is_peak, rsp_is_peak);
               check_field("peak_total", oldest.peak_total, rsp_peak_total);
               check_field("last_of_run", oldest.last_of_run, rsp_last_of_run);
               check_field("frame_done", oldest.frame_done, rsp_frame_done);
            end
         end

         // Any register write restarts the frame
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ROW_TOTAL) row_setting = csr_data;
            else if (csr_index == REG_COL_TOTAL) col_setting = csr_data;
            cur_row        = 0;
            cur_col        = 0;
            peaks_in_frame = '0;
         end

         if (req_valid && !req_stall) take_sample(req_sample);
      end
      pending <= decisions_due.size();
   end

endmodule

>>> bench/tb_strict_local_max_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strict_local_max_3x3_core: stimulus and verdict for the 3x3 peak core
// Runs a directed set of small frames (extreme samples, equal neighbours,
// single row and column, frame wrap, restart by register write), then random
// frame sizes with random content, oversize register values, and a phase where
// the result side holds off long enough to back the core up to its input.
// Both sides idle at random; the checker beside the core does the compare.
// ----------------------------------------------------------------------------
module tb_strict_local_max_3x3_core;
   import slm_pkg::*;

   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_IDLE      = 17;
   localparam int RANDOM_ITEMS  = 55;
   localparam int RUN_LIMIT_NS  = 20_000_000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid;
   logic                       req_stall;
   sample_type                 req_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   sample_type                 rsp_value;
   logic [POS_BITS-1:0]        rsp_row_index;
   logic [POS_BITS-1:0]        rsp_col_index;
   logic                       rsp_is_peak;
   logic [PEAK_BITS-1:0]       rsp_peak_total;
   logic                       rsp_last_of_run;
   logic                       rsp_frame_done;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CFG_BITS-1:0]        csr_data;
   int                         failures;
   int                         pending;

   // Phase controls shared by the sender and the receiver
   bit                         steady = 1'b0;
   bit                         hold_request = 1'b0;

   // 3x3 frame with equal neighbours and both sample extremes
   sample_type directed_grid [9] = '{16'sd100, 16'sd100, -16'sd32768,
                                     16'sd5, 16'sd32767, 16'sd32766,
                                     -16'sd32768, 16'sd32767, 16'sd0};

   always #10 clock = ~clock;

   strict_local_max_3x3_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_row_index   (rsp_row_index),
      .rsp_col_index   (rsp_col_index),
      .rsp_is_peak     (rsp_is_peak),
      .rsp_peak_total  (rsp_peak_total),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   strict_local_max_3x3_checker decision_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_row_index   (rsp_row_index),
      .rsp_col_index   (rsp_col_index),
      .rsp_is_peak     (rsp_is_peak),
      .rsp_peak_total  (rsp_peak_total),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .failures        (failures),
      .pending         (pending)
   );

   function automatic int idle_cycles();
      return steady ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   // Mostly full-range noise, some near-flat values to make ties, some extremes
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         6, 7:    return sample_type'($urandom_range(0, 4) - 2);
         8:       return 16'sh7FFF;
         9:       return 16'sh8000;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Offer one sample beat after a random gap; hold it until taken
   task automatic send_sample(input sample_type s);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_sample(pick_sample());
   endtask

   // Drop valid, drain every decision due, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CFG_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [CFG_BITS-1:0] rows, input logic [CFG_BITS-1:0] cols);
      write_reg(REG_ROW_TOTAL, rows);
      write_reg(REG_COL_TOTAL, cols);
   endtask

   // Result side: random stall per beat, long hold-off on request
   initial begin
      int stall_cycles;
      rsp_stall <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_request) begin
            stall_cycles = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall_cycles = idle_cycles();
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid && !hold_request);
      end
   end

   // Stimulus and verdict
   initial begin
      int random_items;
      int rows_sel;
      int cols_sel;
      int frame_size;
      int count;
      req_valid  <= 1'b0;
      req_sample <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_ROW_TOTAL;
      csr_data   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Frame out of reset is 1x1: every sample is its own peak
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      settle();

      // Zero in both registers clamps to 1x1
      set_frame(8'd0, 8'd0);
      send_sample(16'sd1);
      settle();

      // 3x3 with ties and extremes, then part of the next frame
      set_frame(8'd3, 8'd3);
      foreach (directed_grid[n]) send_sample(directed_grid[n]);
      send_sample(16'sd7);
      send_sample(-16'sd7);
      send_sample(16'sd7);
      send_sample(16'sh7FFF);
      send_sample(16'sd6);
      settle();

      // Single row, then single column; the writes restart the frame above
      set_frame(8'd1, 8'd3);
      send_sample(16'sd3);
      send_sample(16'sd3);
      send_sample(-16'sd1);
      settle();
      set_frame(8'd3, 8'd1);
      send_sample(-16'sd1);
      send_sample(16'sd2);
      send_sample(16'sd2);
      settle();

      // Random small frames, mostly whole frames, some cut short
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         steady   = ($urandom_range(0, 3) == 0);
         rows_sel = $urandom_range(0, 6);
         cols_sel = $urandom_range(0, 8);
         set_frame(CFG_BITS'(rows_sel), CFG_BITS'(cols_sel));
         frame_size = (rows_sel == 0 ? 1 : rows_sel) * (cols_sel == 0 ? 1 : cols_sel);
         count      = frame_size * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, frame_size);
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         send_random(count);
         settle();
         random_items += count;
      end

      // Oversize row and column counts clamp to the maximum
      steady = 1'b0;
      set_frame(8'd255, 8'd1);
      send_random(6);
      settle();
      set_frame(8'd1, 8'd200);
      send_random(6);
      settle();

      // Back up the core: receiver holds off while samples stream in
      steady = 1'b1;
      set_frame(8'd5, 8'd4);
      hold_request = 1'b1;
      send_random(40);
      settle();
      steady = 1'b0;

      if (failures == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #(RUN_LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule
